FILE: hw/rtl/tmedcal_pkg.sv
// Package for the touch sample median calibrator.
// Holds field widths, register reset values, status and register codes and
// the payload structs shared by all modules but the queue. No dependencies.
package tmedcal_pkg;

  localparam int NUM_SAMPLES  = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SAMPLE_W     = 12;
  localparam int SCALE_W      = 16;
  localparam int OFFSET_W     = 16;
  localparam int SCREEN_W     = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int FRAC_W       = 14;  // Q2.14 gain
  localparam int OFFSET_SHIFT = 10;  // 1/16 pixel offset into 1/16384 units

  localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT = SAMPLE_W'(5);
  localparam logic [SAMPLE_W-1:0] EDGE_Y       = SAMPLE_W'(2047);
  localparam logic [SCREEN_W-1:0] SCREEN_MAX   = SCREEN_W'(1023);

  localparam logic [SCALE_W-1:0]         X_SCALE_RST     = 16'd2929;
  localparam logic signed [OFFSET_W-1:0] X_OFFSET_RST    = -16'sd379;
  localparam logic [SCALE_W-1:0]         Y_SCALE_RST     = 16'd4094;
  localparam logic signed [OFFSET_W-1:0] Y_OFFSET_RST    = -16'sd210;
  localparam logic                       SWAP_AXES_RST   = 1'b0;
  localparam logic                       MIRROR_Y_RST    = 1'b1;
  localparam logic [SCREEN_W-1:0]        MIRROR_BASE_RST = 10'd480;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SPREAD = 2'd1,
    ST_EDGE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SCALE     = 3'd0,
    CFG_X_OFFSET    = 3'd1,
    CFG_Y_SCALE     = 3'd2,
    CFG_Y_OFFSET    = 3'd3,
    CFG_SWAP_AXES   = 3'd4,
    CFG_MIRROR_Y    = 3'd5,
    CFG_MIRROR_BASE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
  } sample_t;

  typedef struct packed {
    status_e             status;
    logic [SAMPLE_W-1:0] raw_x;
    logic [SAMPLE_W-1:0] raw_y;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
  } result_t;

  // Entry of the queue between front and back: a sample tagged with frame end.
  typedef struct packed {
    logic    last;
    sample_t smp;
  } qent_t;

  typedef struct packed {
    logic [SCALE_W-1:0]         x_scale;
    logic signed [OFFSET_W-1:0] x_offset;
    logic [SCALE_W-1:0]         y_scale;
    logic signed [OFFSET_W-1:0] y_offset;
    logic                       swap_axes;
    logic                       mirror_y;
    logic [SCREEN_W-1:0]        mirror_base;
  } cfg_t;

endpackage

FILE: hw/rtl/touch_sample_median_calibrator_unit.sv
// Touch sample median calibrator, top level: config registers, front end,
// sample queue, sort/map back end and result queue. Uses tmedcal_pkg.
// Throughput: one sample beat per cycle unless the sample queue is full; a
// frame end is held in the sample queue until the previous frame has left
// the two-stage mapper and a result slot is free.
// Reset: counters and queues empty, config at defaults, sample rows not cleared.
module touch_sample_median_calibrator_unit #(
  parameter int NumSamples = tmedcal_pkg::NUM_SAMPLES,
  parameter int QueueDepth = tmedcal_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  tmedcal_pkg::sample_t                in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output tmedcal_pkg::result_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tmedcal_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tmedcal_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tmedcal_pkg::*;

  cfg_t    cfg_q;
  logic    sq_push, sq_full, sq_pop, sq_empty;
  qent_t   sq_wdata, sq_rdata;
  logic    rq_push, rq_full;
  result_t rq_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale     <= X_SCALE_RST;
      cfg_q.x_offset    <= X_OFFSET_RST;
      cfg_q.y_scale     <= Y_SCALE_RST;
      cfg_q.y_offset    <= Y_OFFSET_RST;
      cfg_q.swap_axes   <= SWAP_AXES_RST;
      cfg_q.mirror_y    <= MIRROR_Y_RST;
      cfg_q.mirror_base <= MIRROR_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_SCALE:     cfg_q.x_scale     <= cfg_wdata_i[SCALE_W-1:0];
        CFG_X_OFFSET:    cfg_q.x_offset    <= $signed(cfg_wdata_i[OFFSET_W-1:0]);
        CFG_Y_SCALE:     cfg_q.y_scale     <= cfg_wdata_i[SCALE_W-1:0];
        CFG_Y_OFFSET:    cfg_q.y_offset    <= $signed(cfg_wdata_i[OFFSET_W-1:0]);
        CFG_SWAP_AXES:   cfg_q.swap_axes   <= cfg_wdata_i[0];
        CFG_MIRROR_Y:    cfg_q.mirror_y    <= cfg_wdata_i[0];
        CFG_MIRROR_BASE: cfg_q.mirror_base <= cfg_wdata_i[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  tmedcal_front #(
    .NumSamples(NumSamples)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .q_full_i  (sq_full),
    .q_push_o  (sq_push),
    .q_data_o  (sq_wdata)
  );

  tmedcal_queue #(
    .Width($bits(qent_t)),
    .Depth(QueueDepth)
  ) u_sample_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sq_push),
    .wdata_i (sq_wdata),
    .full_o  (sq_full),
    .pop_i   (sq_pop),
    .rdata_o (sq_rdata),
    .empty_o (sq_empty)
  );

  tmedcal_back #(
    .NumSamples(NumSamples)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (sq_empty),
    .q_data_i   (sq_rdata),
    .q_pop_o    (sq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_data_o (rq_wdata)
  );

  tmedcal_queue #(
    .Width($bits(result_t)),
    .Depth(QueueDepth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule

FILE: hw/rtl/tmedcal_queue.sv
// Small register FIFO, used between front and back and for results.
// Generic width and depth; no package dependency.
module tmedcal_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/tmedcal_front.sv
// Front end: takes sample beats, counts them within a frame and tags the
// frame's last sample before it enters the sample queue. Uses tmedcal_pkg.
module tmedcal_front #(
  parameter int NumSamples = tmedcal_pkg::NUM_SAMPLES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tmedcal_pkg::sample_t in_data_i,
  output logic                 full_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tmedcal_pkg::qent_t   q_data_o
);
  import tmedcal_pkg::*;

  localparam int CntW = $clog2(NumSamples);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;
  assign last     = (cnt_q == CntW'(NumSamples - 1));

  always_comb begin
    q_data_o.last = last;
    q_data_o.smp  = in_data_i;
    cnt_d = cnt_q;
    if (q_push_o) begin
      cnt_d = last ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/tmedcal_back.sv
// Back end: insertion-sorts each frame into two rows of cells, captures the
// middle pair, then checks, averages and maps through a two-stage pipeline.
// Uses tmedcal_pkg.
module tmedcal_back #(
  parameter int NumSamples = tmedcal_pkg::NUM_SAMPLES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmedcal_pkg::cfg_t    cfg_i,
  input  logic                 q_empty_i,
  input  tmedcal_pkg::qent_t   q_data_i,
  output logic                 q_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output tmedcal_pkg::result_t res_data_o
);
  import tmedcal_pkg::*;

  localparam int CntW   = $clog2(NumSamples);
  localparam int MidLo  = NumSamples / 2 - 1;
  localparam int MidHi  = NumSamples / 2;
  localparam int ProdW  = SAMPLE_W + SCALE_W;
  localparam int AccW   = ProdW + 2;
  localparam int QuotW  = AccW - FRAC_W;

  // sorted rows, valid below index fill_q
  logic [SAMPLE_W-1:0] xs_q [NumSamples];
  logic [SAMPLE_W-1:0] ys_q [NumSamples];
  logic [SAMPLE_W-1:0] xs_d [NumSamples];
  logic [SAMPLE_W-1:0] ys_d [NumSamples];
  logic [NumSamples-1:0] gtx, gty;
  logic [CntW-1:0] fill_q, fill_d;

  logic                mid_v_q;
  logic [SAMPLE_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q;

  logic                prod_v_q;
  logic [ProdW-1:0]    prodx_q, prody_q;
  status_e             st_q;
  logic [SAMPLE_W-1:0] rx_q, ry_q;

  logic [SAMPLE_W:0]   sumx, sumy;
  logic [SAMPLE_W-1:0] rx, ry, srcx, srcy;
  logic                okx, oky;
  status_e             st;
  logic [ProdW-1:0]    prodx, prody;

  logic signed [AccW-1:0]  offx, offy, accx, accy;
  logic signed [QuotW-1:0] qx, qy;
  logic [SCREEN_W-1:0]     mx, my;
  logic signed [SCREEN_W:0] mdiff;

  function automatic logic [SCREEN_W-1:0] clamp_screen(input logic signed [QuotW-1:0] v);
    logic [SCREEN_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(QuotW-SCREEN_W){1'b0}}, SCREEN_MAX})) begin
      r = SCREEN_MAX;
    end else begin
      r = v[SCREEN_W-1:0];
    end
    return r;
  endfunction

  // A frame end waits until the mapper is free and a result slot is open.
  assign q_pop_o = !q_empty_i &&
                   (!q_data_i.last || (!mid_v_q && !prod_v_q && !res_full_i));

  always_comb begin
    for (int k = 0; k < NumSamples; k++) begin
      gtx[k] = (CntW'(k) < fill_q) && (xs_q[k] > q_data_i.smp.x_sample);
      gty[k] = (CntW'(k) < fill_q) && (ys_q[k] > q_data_i.smp.y_sample);
    end
    for (int k = 0; k < NumSamples; k++) begin
      xs_d[k] = (gtx[k] || CntW'(k) == fill_q) ? q_data_i.smp.x_sample : xs_q[k];
      ys_d[k] = (gty[k] || CntW'(k) == fill_q) ? q_data_i.smp.y_sample : ys_q[k];
    end
    // cells above the insertion point shift up by one
    for (int k = 1; k < NumSamples; k++) begin
      if (gtx[k-1]) begin
        xs_d[k] = xs_q[k-1];
      end
      if (gty[k-1]) begin
        ys_d[k] = ys_q[k-1];
      end
    end
    fill_d = fill_q;
    if (q_pop_o) begin
      fill_d = q_data_i.last ? '0 : fill_q + CntW'(1);
    end
  end

  // stage 1: spread and edge check, mean, axis select, gain multiply
  always_comb begin
    sumx = {1'b0, xlo_q} + {1'b0, xhi_q};
    sumy = {1'b0, ylo_q} + {1'b0, yhi_q};
    rx   = sumx[SAMPLE_W:1];
    ry   = sumy[SAMPLE_W:1];
    okx  = (xhi_q - xlo_q) <= SPREAD_LIMIT;
    oky  = (yhi_q - ylo_q) <= SPREAD_LIMIT;
    if (!okx || !oky) begin
      st = ST_SPREAD;
    end else if (rx == '0 || ry == EDGE_Y) begin
      st = ST_EDGE;
    end else begin
      st = ST_OK;
    end
    srcx  = cfg_i.swap_axes ? ry : rx;
    srcy  = cfg_i.swap_axes ? rx : ry;
    prodx = ProdW'(srcx) * ProdW'(cfg_i.x_scale);
    prody = ProdW'(srcy) * ProdW'(cfg_i.y_scale);
  end

  // stage 2: offset, floor shift, clamp, mirror; a failed frame's fields are zeroed
  always_comb begin
    offx = $signed({{(AccW-OFFSET_W){cfg_i.x_offset[OFFSET_W-1]}}, cfg_i.x_offset});
    offy = $signed({{(AccW-OFFSET_W){cfg_i.y_offset[OFFSET_W-1]}}, cfg_i.y_offset});
    accx = $signed({2'b00, prodx_q}) + (offx <<< OFFSET_SHIFT);
    accy = $signed({2'b00, prody_q}) + (offy <<< OFFSET_SHIFT);
    qx   = accx[AccW-1:FRAC_W];
    qy   = accy[AccW-1:FRAC_W];
    mx   = clamp_screen(qx);
    my   = clamp_screen(qy);
    mdiff = $signed({1'b0, cfg_i.mirror_base}) - $signed({1'b0, my});
    if (cfg_i.mirror_y) begin
      my = (mdiff < 0) ? '0 : mdiff[SCREEN_W-1:0];
    end
    res_push_o = prod_v_q;
    res_data_o.status = st_q;
    if (st_q == ST_OK) begin
      res_data_o.raw_x    = rx_q;
      res_data_o.raw_y    = ry_q;
      res_data_o.screen_x = mx;
      res_data_o.screen_y = my;
    end else begin
      res_data_o.raw_x    = '0;
      res_data_o.raw_y    = '0;
      res_data_o.screen_x = '0;
      res_data_o.screen_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      mid_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      mid_v_q  <= q_pop_o && q_data_i.last;
      prod_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      xs_q <= xs_d;
      ys_q <= ys_d;
    end
    if (q_pop_o && q_data_i.last) begin
      xlo_q <= xs_d[MidLo];
      xhi_q <= xs_d[MidHi];
      ylo_q <= ys_d[MidLo];
      yhi_q <= ys_d[MidHi];
    end
    if (mid_v_q) begin
      prodx_q <= prodx;
      prody_q <= prody;
      st_q    <= st;
      rx_q    <= rx;
      ry_q    <= ry;
    end
  end

endmodule
